@@ hw/rtl/cmfuv_pkg.sv @@
// ----------------------------------------------------------------------------
// cmfuv_pkg: shared types and constants for cube map face / uv select
// Widths, face codes and divider pipeline shape.
// ----------------------------------------------------------------------------
package cmfuv_pkg;

    localparam int COMP_BITS     = 16;                        // direction component width
    localparam int UV_BITS       = 16;                        // uv fraction bits
    localparam int DIV_STEP_BITS = 2;                         // quotient bits per stage
    localparam int DIV_STAGES    = UV_BITS / DIV_STEP_BITS;   // divider pipeline depth
    localparam int NUM_W         = COMP_BITS + 1;             // s + ma and 2 * ma
    localparam int REM_W         = COMP_BITS + 2;             // shifted partial remainder

    typedef enum logic [2:0] {
        FACE_TOP    = 3'd0,
        FACE_BOTTOM = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_FRONT  = 3'd4,
        FACE_BACK   = 3'd5
    } t_face;

    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [UV_BITS-1:0] t_uv;

endpackage

@@ hw/rtl/cmfuv_div.sv @@
// ----------------------------------------------------------------------------
// cmfuv_div: pipelined restoring divider
// Quotient of num * 2^UV_BITS / den for num < den, DIV_STEP_BITS bits a stage.
// ----------------------------------------------------------------------------
module cmfuv_div import cmfuv_pkg::*; (
    input  logic i_clk,
    input  t_num i_num,
    input  t_num i_den,
    output t_uv  o_quo
);

    logic [REM_W-1:0] r_rem [DIV_STAGES];
    t_num             r_den [DIV_STAGES];
    t_uv              r_quo [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [REM_W-1:0] w_rem_in;
        t_num             w_den_in;
        t_uv              w_quo_in;
        logic [REM_W-1:0] n_rem;
        t_uv              n_quo;

        if (g == 0) begin : g_first
            assign w_rem_in = {1'b0, i_num};
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_den_in = r_den[g-1];
            assign w_quo_in = r_quo[g-1];
        end

        always_comb begin
            logic [REM_W-1:0] v_sh;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int k = 0; k < DIV_STEP_BITS; k++) begin
                v_sh = {n_rem[REM_W-2:0], 1'b0};
                if (v_sh >= {1'b0, w_den_in}) begin
                    n_rem = v_sh - {1'b0, w_den_in};
                    n_quo = {n_quo[UV_BITS-2:0], 1'b1};
                end else begin
                    n_rem = v_sh;
                    n_quo = {n_quo[UV_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_den[g] <= w_den_in;
            r_quo[g] <= n_quo;
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

@@ hw/rtl/cube_map_face_uv_select_core.sv @@
// ----------------------------------------------------------------------------
// cube_map_face_uv_select_core: cube face and face uv from a direction
// Picks the major axis face, then u = (s/ma+1)/2, v = (t/ma+1)/2 in Q0.16.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------------
//  input    | start, busy (in on !busy) | i_dir_x, i_dir_y, i_dir_z
//  result   | o_valid strobe, one cycle | o_face, o_coord_u, o_coord_v,
//           |                           | o_degenerate
//
//  One word per clock. A word taken passes stage A, stage B, the DIV_STAGES
//  divider stages and the output register, then shows on the result ports
//  for one cycle; the depth is set by the two long-division lanes at 2
//  quotient bits per stage. Synchronous active-low reset empties the pipe;
//  busy is high during reset and until the run flag sets, then stays low:
//  nothing downstream can stall, so the pipe always advances.
// ----------------------------------------------------------------------------
module cube_map_face_uv_select_core import cmfuv_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [COMP_BITS-1:0] i_dir_x,
    input  logic signed [COMP_BITS-1:0] i_dir_y,
    input  logic signed [COMP_BITS-1:0] i_dir_z,
    output logic                        o_valid,
    output logic [2:0]                  o_face,
    output logic [UV_BITS-1:0]          o_coord_u,
    output logic [UV_BITS-1:0]          o_coord_v,
    output logic                        o_degenerate
);

    localparam int LATENCY = DIV_STAGES + 3;   // accept edge to strobe sample

    // ---------------- run flag: busy in and right after reset only ----------
    logic r_run;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end
    assign busy = !r_run;

    // ---------------- stage A: magnitudes, major axis, s/t select ----------
    logic [COMP_BITS-1:0]    w_ax, w_ay, w_az;
    logic signed [NUM_W-1:0] w_xe, w_ye, w_ze;
    logic [COMP_BITS-1:0]    n_a_ma;
    logic signed [NUM_W-1:0] n_a_s, n_a_t;
    t_face                   n_a_face;

    assign w_ax = i_dir_x[COMP_BITS-1] ? COMP_BITS'(-i_dir_x) : COMP_BITS'(i_dir_x);
    assign w_ay = i_dir_y[COMP_BITS-1] ? COMP_BITS'(-i_dir_y) : COMP_BITS'(i_dir_y);
    assign w_az = i_dir_z[COMP_BITS-1] ? COMP_BITS'(-i_dir_z) : COMP_BITS'(i_dir_z);
    assign w_xe = {i_dir_x[COMP_BITS-1], i_dir_x};
    assign w_ye = {i_dir_y[COMP_BITS-1], i_dir_y};
    assign w_ze = {i_dir_z[COMP_BITS-1], i_dir_z};

    always_comb begin
        // ties favor X, then Y
        priority if (w_ax >= w_ay && w_ax >= w_az) begin
            n_a_ma = w_ax;
            n_a_t  = w_ye;
            if (!i_dir_x[COMP_BITS-1] && i_dir_x != '0) begin
                n_a_face = FACE_RIGHT;
                n_a_s    = w_ze;
            end else begin
                n_a_face = FACE_LEFT;
                n_a_s    = -w_ze;
            end
        end else if (w_ay >= w_az) begin
            n_a_ma = w_ay;
            n_a_s  = w_xe;
            if (!i_dir_y[COMP_BITS-1] && i_dir_y != '0) begin
                n_a_face = FACE_TOP;
                n_a_t    = w_ze;
            end else begin
                n_a_face = FACE_BOTTOM;
                n_a_t    = -w_ze;
            end
        end else begin
            n_a_ma = w_az;
            n_a_t  = w_ye;
            if (!i_dir_z[COMP_BITS-1] && i_dir_z != '0) begin
                n_a_face = FACE_BACK;
                n_a_s    = -w_xe;
            end else begin
                n_a_face = FACE_FRONT;
                n_a_s    = w_xe;
            end
        end
    end

    logic                    r_a_valid;
    logic [COMP_BITS-1:0]    r_a_ma;
    logic signed [NUM_W-1:0] r_a_s, r_a_t;
    t_face                   r_a_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
        r_a_ma   <= n_a_ma;
        r_a_s    <= n_a_s;
        r_a_t    <= n_a_t;
        r_a_face <= n_a_face;
    end

    // ---------------- stage B: numerators, divisor, full-scale flags -------
    t_num n_b_num_u, n_b_num_v, n_b_den;

    assign n_b_num_u = r_a_s + $signed({1'b0, r_a_ma});   // in [0, 2*ma]
    assign n_b_num_v = r_a_t + $signed({1'b0, r_a_ma});
    assign n_b_den   = {r_a_ma, 1'b0};

    logic  r_b_valid, r_b_degen, r_b_sat_u, r_b_sat_v;
    t_num  r_b_num_u, r_b_num_v, r_b_den;
    t_face r_b_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_num_u <= n_b_num_u;
        r_b_num_v <= n_b_num_v;
        r_b_den   <= n_b_den;
        r_b_sat_u <= (n_b_num_u == n_b_den);   // s == ma: quotient is 2^UV_BITS
        r_b_sat_v <= (n_b_num_v == n_b_den);
        r_b_degen <= (r_a_ma == '0);
        r_b_face  <= r_a_face;
    end

    // ---------------- divider lanes (zero divisor gives junk, masked) ------
    t_uv w_quo_u, w_quo_v;

    cmfuv_div u_div_u (
        .i_clk (i_clk),
        .i_num (r_b_num_u),
        .i_den (r_b_den),
        .o_quo (w_quo_u)
    );

    cmfuv_div u_div_v (
        .i_clk (i_clk),
        .i_num (r_b_num_v),
        .i_den (r_b_den),
        .o_quo (w_quo_v)
    );

    // ---------------- sideband delay line, aligned with the dividers -------
    logic  r_d_valid [DIV_STAGES];
    logic  r_d_degen [DIV_STAGES];
    logic  r_d_sat_u [DIV_STAGES];
    logic  r_d_sat_v [DIV_STAGES];
    t_face r_d_face  [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_side
        logic  w_valid, w_degen, w_sat_u, w_sat_v;
        t_face w_face;

        if (g == 0) begin : g_first
            assign w_valid = r_b_valid;
            assign w_degen = r_b_degen;
            assign w_sat_u = r_b_sat_u;
            assign w_sat_v = r_b_sat_v;
            assign w_face  = r_b_face;
        end else begin : g_next
            assign w_valid = r_d_valid[g-1];
            assign w_degen = r_d_degen[g-1];
            assign w_sat_u = r_d_sat_u[g-1];
            assign w_sat_v = r_d_sat_v[g-1];
            assign w_face  = r_d_face[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[g] <= 1'b0;
            end else begin
                r_d_valid[g] <= w_valid;
            end
            r_d_degen[g] <= w_degen;
            r_d_sat_u[g] <= w_sat_u;
            r_d_sat_v[g] <= w_sat_v;
            r_d_face[g]  <= w_face;
        end
    end

    // ---------------- output register: saturate, zero-vector override ------
    logic  r_o_valid, r_o_degen;
    t_uv   r_o_u, r_o_v;
    t_face r_o_face;
    t_uv   n_o_u, n_o_v;
    t_face n_o_face;
    logic  w_last_degen;

    assign w_last_degen = r_d_degen[DIV_STAGES-1];

    always_comb begin
        n_o_face = r_d_face[DIV_STAGES-1];
        n_o_u    = r_d_sat_u[DIV_STAGES-1] ? '1 : w_quo_u;
        n_o_v    = r_d_sat_v[DIV_STAGES-1] ? '1 : w_quo_v;
        if (w_last_degen) begin
            n_o_face = FACE_TOP;
            n_o_u    = '0;
            n_o_v    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_d_valid[DIV_STAGES-1];
        end
        r_o_degen <= w_last_degen;
        r_o_u     <= n_o_u;
        r_o_v     <= n_o_v;
        r_o_face  <= n_o_face;
    end

    assign o_valid      = r_o_valid;
    assign o_face       = r_o_face;
    assign o_coord_u    = r_o_u;
    assign o_coord_v    = r_o_v;
    assign o_degenerate = r_o_degen;

    // ---------------- checks ------------------------------------------------
    // every strobe traces back to an accepted word a fixed depth earlier
    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching accepted word");

    // zero vector leaves face top and zero coordinates
    a_degen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_face == FACE_TOP && o_coord_u == '0
                                    && o_coord_v == '0)
        else $error("degenerate result with nonzero face or coordinates");

    // once out of reset the pipe never refuses a word
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised after reset");

    // a full-scale u lane forces all ones unless the vector is zero
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_d_sat_u[DIV_STAGES-1] && !w_last_degen) |-> r_o_u == '1)
        else $error("full-scale u not saturated");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for cube_map_face_uv_select_core
// Drives direction words through the start/busy handshake with random gaps,
// predicts face, u, v and degenerate flag (or takes typed-in ones) for each
// accepted word and checks each o_valid strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top import cmfuv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_WORDS = 1000;
    localparam int DRAIN_CYC  = 40;          // generous tail for the pipe to drain
    localparam int MAX_GAP    = 13;
    localparam longint UV_MAX = (longint'(1) << UV_BITS) - 1;

    // one result word as it leaves the core
    typedef struct packed {
        t_face face;
        t_uv   u;
        t_uv   v;
        logic  degen;
    } t_face_uv_word;

    // directed row: input vector plus, where obvious, a typed-in answer
    typedef struct packed {
        logic signed [COMP_BITS-1:0] x;
        logic signed [COMP_BITS-1:0] y;
        logic signed [COMP_BITS-1:0] z;
        bit                          typed;
        t_face_uv_word               want;
    } t_dir_row;

    localparam int N_ROWS = 22;

    // -------------------------------------------------------------------------
    // Directed table. typed = 1 rows carry their expected word; the rest go
    // through the predictor like the random words do.
    // -------------------------------------------------------------------------
    t_dir_row dir_rows [N_ROWS] = '{
        // zero vector: face top, degenerate flag
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{FACE_TOP,    16'd0,     16'd0,     1'b1}},
        // pure axes at both extremes and at magnitude one: face center
        '{16'sd32767,  16'sd0,      16'sd0,      1'b1, '{FACE_RIGHT,  16'd32768, 16'd32768, 1'b0}},
        '{-16'sd32768, 16'sd0,      16'sd0,      1'b1, '{FACE_LEFT,   16'd32768, 16'd32768, 1'b0}},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b1, '{FACE_TOP,    16'd32768, 16'd32768, 1'b0}},
        '{16'sd0,      -16'sd32768, 16'sd0,      1'b1, '{FACE_BOTTOM, 16'd32768, 16'd32768, 1'b0}},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b1, '{FACE_BACK,   16'd32768, 16'd32768, 1'b0}},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, '{FACE_FRONT,  16'd32768, 16'd32768, 1'b0}},
        '{16'sd1,      16'sd0,      16'sd0,      1'b1, '{FACE_RIGHT,  16'd32768, 16'd32768, 1'b0}},
        '{16'sd0,      16'sd0,      -16'sd1,     1'b1, '{FACE_FRONT,  16'd32768, 16'd32768, 1'b0}},
        // three-way tie: X wins, s = ma saturates
        '{16'sd100,    16'sd100,    16'sd100,    1'b1, '{FACE_RIGHT,  16'hFFFF,  16'hFFFF,  1'b0}},
        '{-16'sd100,   -16'sd100,   -16'sd100,   1'b1, '{FACE_LEFT,   16'hFFFF,  16'd0,     1'b0}},
        // Y/Z tie goes to Y, X/Y tie goes to X
        '{16'sd0,      16'sd7,      -16'sd7,     1'b1, '{FACE_TOP,    16'd32768, 16'd0,     1'b0}},
        '{-16'sd1,     -16'sd1,     16'sd0,      1'b1, '{FACE_LEFT,   16'd32768, 16'd0,     1'b0}},
        // most negative held as 32768, no wrap
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, '{FACE_LEFT,   16'hFFFF,  16'd0,     1'b0}},
        '{16'sd32767,  -16'sd32768, 16'sd0,      1'b1, '{FACE_BOTTOM, 16'hFFFF,  16'd32768, 1'b0}},
        '{16'sd32767,  16'sd32767,  -16'sd32768, 1'b1, '{FACE_FRONT,  16'hFFFF,  16'hFFFF,  1'b0}},
        // off-center points, predictor only
        '{16'sd5,      -16'sd5,     16'sd3,      1'b0, '0},
        '{16'sd12345,  -16'sd23456, 16'sd3000,   1'b0, '0},
        '{-16'sd7,     16'sd2,      -16'sd30000, 1'b0, '0},
        '{16'sd20000,  -16'sd19999, 16'sd19998,  1'b0, '0},
        '{-16'sd1,     16'sd32767,  -16'sd32767, 1'b0, '0},
        '{-16'sd32767, 16'sd1234,   16'sd32767,  1'b0, '0}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
    logic                        o_valid;
    logic [2:0]                  o_face;
    logic [UV_BITS-1:0]          o_coord_u;
    logic [UV_BITS-1:0]          o_coord_v;
    logic                        o_degenerate;

    t_face_uv_word pending_uv_q [$];     // predictions waiting for their strobe

    int  mismatches   = 0;
    int  words_in     = 0;
    int  words_out    = 0;
    int  degen_seen   = 0;
    int  sat_seen     = 0;
    int  face_hits [6];
    bit  calm_stretch = 1'b0;            // no sender gaps while set

    cube_map_face_uv_select_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_dir_x      (dir_x),
        .i_dir_y      (dir_y),
        .i_dir_z      (dir_z),
        .o_valid      (o_valid),
        .o_face       (o_face),
        .o_coord_u    (o_coord_u),
        .o_coord_v    (o_coord_v),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------------
    // floor((c + ma) * 2^UV / (2 ma)), clamped to the top code
    function automatic t_uv face_uv_coord(input longint c, input longint ma);
        longint q;
        q = ((c + ma) <<< UV_BITS) / (2 * ma);
        if (q > UV_MAX) q = UV_MAX;
        return t_uv'(q);
    endfunction

    function automatic t_face_uv_word predict_face_uv(
        input logic signed [COMP_BITS-1:0] x,
        input logic signed [COMP_BITS-1:0] y,
        input logic signed [COMP_BITS-1:0] z
    );
        longint        sx, sy, sz, ax, ay, az, ma, s_c, t_c;
        t_face_uv_word w;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        ma = ax;
        if (ay > ma) ma = ay;
        if (az > ma) ma = az;
        w = '0;
        if (ma == 0) begin
            w.face  = FACE_TOP;
            w.degen = 1'b1;
            return w;
        end
        // ties resolve X, then Y, then Z
        if (ma == ax) begin
            if (sx > 0) begin w.face = FACE_RIGHT; s_c = sz;  t_c = sy;  end
            else        begin w.face = FACE_LEFT;  s_c = -sz; t_c = sy;  end
        end else if (ma == ay) begin
            if (sy > 0) begin w.face = FACE_TOP;    s_c = sx; t_c = sz;  end
            else        begin w.face = FACE_BOTTOM; s_c = sx; t_c = -sz; end
        end else begin
            if (sz > 0) begin w.face = FACE_BACK;  s_c = -sx; t_c = sy; end
            else        begin w.face = FACE_FRONT; s_c = sx;  t_c = sy; end
        end
        w.u = face_uv_coord(s_c, ma);
        w.v = face_uv_coord(t_c, ma);
        return w;
    endfunction

    // -------------------------------------------------------------------------
    // Sender: called on a falling edge, returns on a falling edge once a rising
    // edge has taken the word. The gap is drawn per word; start is low during it.
    // -------------------------------------------------------------------------
    task automatic send_dir_word(
        input logic signed [COMP_BITS-1:0] x,
        input logic signed [COMP_BITS-1:0] y,
        input logic signed [COMP_BITS-1:0] z,
        input bit                          typed,
        input t_face_uv_word               typed_word
    );
        int gap;
        gap = calm_stretch ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        // busy seen here is its value before the edge: the accept condition
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_uv_q.push_back(typed ? typed_word : predict_face_uv(x, y, z));
        words_in++;
        @(negedge i_clk);
    endtask

    // random component with a bias toward the interesting corners
    function automatic logic signed [COMP_BITS-1:0] pick_comp(input int flavor);
        logic signed [COMP_BITS-1:0] c;
        case (flavor)
            0: c = COMP_BITS'($urandom);                             // any 16-bit pattern
            1: c = COMP_BITS'($signed($urandom_range(0, 16)) - 8);   // small: ties, zeros
            default: begin
                case ($urandom_range(0, 5))
                    0: c = 16'sh8000;
                    1: c = 16'sh8001;
                    2: c = -16'sd1;
                    3: c = 16'sd0;
                    4: c = 16'sd1;
                    default: c = 16'sh7FFF;
                endcase
            end
        endcase
        return c;
    endfunction

    // -------------------------------------------------------------------------
    // Result checker: each strobe is compared against the oldest prediction.
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_face_uv_word exp_w;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            words_out++;
            if (pending_uv_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word face=%0d u=%0d v=%0d degen=%0b",
                         $time, o_face, o_coord_u, o_coord_v, o_degenerate);
            end else begin
                exp_w = pending_uv_q.pop_front();
                if (o_face !== exp_w.face) begin
                    mismatches++;
                    $display("%0t: face mismatch expected %0d actual %0d",
                             $time, exp_w.face, o_face);
                end
                if (o_coord_u !== exp_w.u) begin
                    mismatches++;
                    $display("%0t: coord_u mismatch expected %0d actual %0d",
                             $time, exp_w.u, o_coord_u);
                end
                if (o_coord_v !== exp_w.v) begin
                    mismatches++;
                    $display("%0t: coord_v mismatch expected %0d actual %0d",
                             $time, exp_w.v, o_coord_v);
                end
                if (o_degenerate !== exp_w.degen) begin
                    mismatches++;
                    $display("%0t: degenerate mismatch expected %0b actual %0b",
                             $time, exp_w.degen, o_degenerate);
                end
                if (exp_w.degen) degen_seen++;
                else if (int'(exp_w.face) < 6) face_hits[exp_w.face]++;
                if (exp_w.u == t_uv'(UV_MAX) || exp_w.v == t_uv'(UV_MAX)) sat_seen++;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial begin
        int            flavor;
        int            drain;
        t_face_uv_word none;
        none    = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        dir_x   = '0;
        dir_y   = '0;
        dir_z   = '0;
        foreach (face_hits[f]) face_hits[f] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows, back to back at first so the table also hits full rate
        calm_stretch = 1'b1;
        foreach (dir_rows[r]) begin
            if (r == N_ROWS / 2) calm_stretch = 1'b0;
            send_dir_word(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                          dir_rows[r].typed, dir_rows[r].want);
        end

        // random words; sender switches between gap-free bursts and random gaps
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 64 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
            flavor = $urandom_range(0, 9);
            if (flavor < 6) flavor = 0;
            else if (flavor < 8) flavor = 1;
            else flavor = 2;
            // one word in ten: x a corner value, y small, z a random value shifted right by 4
            if ($urandom_range(0, 9) == 0)
                send_dir_word(pick_comp(2), pick_comp(1), pick_comp(0) >>> 4, 1'b0, none);
            else
                send_dir_word(pick_comp(flavor), pick_comp(flavor), pick_comp(flavor),
                              1'b0, none);
        end
        start <= 1'b0;

        // let the pipe drain, bounded
        drain = 0;
        while (pending_uv_q.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (pending_uv_q.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected word(s) never arrived", $time, pending_uv_q.size());
        end

        $display("covered %0d words in, %0d out; faces t/b/l/r/f/k = %0d/%0d/%0d/%0d/%0d/%0d",
                 words_in, words_out, face_hits[0], face_hits[1], face_hits[2],
                 face_hits[3], face_hits[4], face_hits[5]);
        $display("zero vectors %0d, saturated coordinates %0d, mismatches %0d",
                 degen_seen, sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("cube_map_face_uv_select_core regression: pass");
        end else begin
            $display("cube_map_face_uv_select_core regression: fail");
        end
        $finish;
    end

    // watchdog: about 1k words with the largest gaps take ~0.2 ms
    initial begin
        #5ms;
        $display("timeout waiting on the core");
        $display("cube_map_face_uv_select_core regression: fail");
        $finish;
    end

endmodule
